### design/ccfe_pkg.sv
package ccfe_pkg;

  // default number of thrust words in a frame
  localparam int THRUST_CHANNELS_DEF = 4;
  // thrust words that have an input field of their own
  localparam int THRUST_FIELDS = 4;

  // frame builder to encoder queue
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VERSION = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_TYPE     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LENGTH   = CFG_INDEX_W'(2);

  localparam logic [7:0] PROTOCOL_VERSION_RST = 8'd1;
  localparam logic [7:0] MESSAGE_TYPE_RST     = 8'd1;
  localparam logic [7:0] PAYLOAD_LENGTH_RST   = 8'd17;

  // flag byte bit positions
  localparam int FLAG_BIT_EMERGENCY = 3;
  localparam int FLAG_BIT_GREEN     = 2;
  localparam int FLAG_BIT_YELLOW    = 1;
  localparam int FLAG_BIT_RED       = 0;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] COBS_DELIM = 8'h00;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CRC,
    FS_PUSH
  } front_state_t;

  // one message byte through the msb-first crc register
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] r;
    r = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### design/ccfe_front.sv
module ccfe_front import ccfe_pkg::*; #(
  parameter int THRUST_CHANNELS = THRUST_CHANNELS_DEF,
  localparam int RAW_LEN = 8 + 4 * THRUST_CHANNELS,
  localparam int BODY_LEN = RAW_LEN - 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            thrust_0,
  input  logic [31:0]            thrust_1,
  input  logic [31:0]            thrust_2,
  input  logic [31:0]            thrust_3,
  input  logic                   flag_emergency,
  input  logic                   flag_green,
  input  logic                   flag_yellow,
  input  logic                   flag_red,
  input  logic [15:0]            sequence_number,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [RAW_LEN*8-1:0]   push_data
);

  localparam int CW = $clog2(BODY_LEN);

  logic [7:0] protocol_version;
  logic [7:0] message_type;
  logic [7:0] payload_length;

  front_state_t state, state_next;
  logic [CW-1:0]         cnt;
  logic [15:0]           crc;
  logic [BODY_LEN*8-1:0] body;
  logic [BODY_LEN*8-1:0] body_next;
  logic [31:0]           thr [THRUST_FIELDS];
  logic                  accept;
  logic [7:0]            flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= PROTOCOL_VERSION_RST;
      message_type     <= MESSAGE_TYPE_RST;
      payload_length   <= PAYLOAD_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROTOCOL_VERSION: protocol_version <= cfg_data;
        REG_MESSAGE_TYPE:     message_type     <= cfg_data;
        REG_PAYLOAD_LENGTH:   payload_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign thr[0] = thrust_0;
  assign thr[1] = thrust_1;
  assign thr[2] = thrust_2;
  assign thr[3] = thrust_3;

  always_comb begin
    flags = 8'h00;
    flags[FLAG_BIT_EMERGENCY] = flag_emergency;
    flags[FLAG_BIT_GREEN]     = flag_green;
    flags[FLAG_BIT_YELLOW]    = flag_yellow;
    flags[FLAG_BIT_RED]       = flag_red;
  end

  // header, little-endian thrust words, flag byte
  assign body_next[7:0]   = protocol_version;
  assign body_next[15:8]  = message_type;
  assign body_next[31:16] = sequence_number;
  assign body_next[39:32] = payload_length;
  assign body_next[BODY_LEN*8-1 -: 8] = flags;

  for (genvar ch = 0; ch < THRUST_CHANNELS; ch++) begin : g_word
    if (ch < THRUST_FIELDS) begin : g_field
      assign body_next[(5 + 4 * ch) * 8 +: 32] = thr[ch];
    end else begin : g_zero
      assign body_next[(5 + 4 * ch) * 8 +: 32] = 32'h0;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = FS_CRC;
      end
      FS_CRC: begin
        if (cnt == CW'(BODY_LEN - 1)) state_next = FS_PUSH;
      end
      FS_PUSH: begin
        push_valid = 1'b1;
        in_ready   = push_ready;
        if (push_ready) state_next = in_valid ? FS_CRC : FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one byte of crc per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      body <= body_next;
      crc  <= CRC_INIT;
      cnt  <= '0;
    end else if (state == FS_CRC) begin
      crc <= crc16_byte(crc, body[cnt*8 +: 8]);
      cnt <= cnt + CW'(1);
    end
  end

  // crc goes out low byte first, so it simply sits above the body
  assign push_data = {crc, body};

endmodule

### design/ccfe_queue.sv
module ccfe_queue import ccfe_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != NW'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slot[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= rd_ptr + PW'(1);
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot[wr_ptr] <= wr_data;
  end

endmodule

### design/ccfe_back.sv
module ccfe_back import ccfe_pkg::*; #(
  parameter int THRUST_CHANNELS = THRUST_CHANNELS_DEF,
  localparam int RAW_LEN = 8 + 4 * THRUST_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  output logic                 frame_ready,
  input  logic [RAW_LEN*8-1:0] frame_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           frame_byte,
  output logic                 last_byte
);

  localparam int KW = $clog2(RAW_LEN + 2);
  localparam int IW = $clog2(RAW_LEN + 1);

  logic                     busy;
  logic [KW-1:0]            k;
  logic [RAW_LEN*8-1:0]     rest;
  logic [(RAW_LEN+1)*8-1:0] sv;
  logic [IW-1:0]            zidx;
  logic [7:0]               code;
  logic [7:0]               byte_sel;
  logic                     adv;
  logic                     fin;
  logic                     load;

  // step 0 emits the first code byte, steps 1..RAW_LEN walk the raw bytes,
  // the final step is the delimiter
  assign adv  = busy && (!out_valid || out_ready);
  assign fin  = adv && (k == KW'(RAW_LEN + 1));
  assign load = frame_valid && (!busy || fin);
  assign frame_ready = load;

  // bytes not yet sent, zero padded so the frame end reads as a zero
  always_comb begin
    if (k == '0) begin
      sv = {8'h00, rest};
    end else begin
      sv = {16'h0000, rest[RAW_LEN*8-1:8]};
    end
  end

  // block length up to the next zero; frames stay far below 254 bytes
  always_comb begin
    zidx = IW'(RAW_LEN);
    for (int i = RAW_LEN; i >= 0; i--) begin
      if (sv[i*8 +: 8] == 8'h00) zidx = IW'(i);
    end
  end

  assign code = 8'(zidx) + 8'd1;

  always_comb begin
    if (k == '0) begin
      byte_sel = code;
    end else if (k == KW'(RAW_LEN + 1)) begin
      byte_sel = COBS_DELIM;
    end else if (rest[7:0] != 8'h00) begin
      byte_sel = rest[7:0];
    end else begin
      byte_sel = code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (fin) begin
        busy <= 1'b0;
      end else if (adv) begin
        k <= k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_byte <= byte_sel;
      last_byte  <= fin;
    end
    if (load) begin
      rest <= frame_data;
    end else if (adv && k != '0) begin
      rest <= {8'h00, rest[RAW_LEN*8-1:8]};
    end
  end

endmodule

### design/crc_cobs_command_frame_encoder.sv
// command frame encoder: crc-16/ccitt-false protected frame, cobs framed
//
// in channel (in_valid/in_ready): one command per beat, four thrust words,
// four flag bits and a sequence number. out channel (out_valid/out_ready):
// one wire byte per beat, last_byte marks the zero delimiter.
// cfg channel (cfg_valid/cfg_ready, always ready): cfg_index 0 protocol
// version, 1 message type, 2 payload length; other indexes are ignored.
//
// a frame of RAW_LEN = 8 + 4*THRUST_CHANNELS bytes (24 by default) leaves
// as RAW_LEN + 2 beats (26). the front builds the frame and runs the crc one
// byte per cycle over its RAW_LEN - 2 body bytes, the back sends one byte per
// cycle while the receiver is ready, so the output byte rate sets throughput.
// a two-frame queue sits between front and back. when the receiver stalls
// the output byte holds; the front keeps taking commands until the queue and
// its own frame register are full. reset restores the register defaults
// (1, 1, 17) and drops any frame.
module crc_cobs_command_frame_encoder import ccfe_pkg::*; #(
  parameter int THRUST_CHANNELS = THRUST_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            thrust_0,
  input  logic [31:0]            thrust_1,
  input  logic [31:0]            thrust_2,
  input  logic [31:0]            thrust_3,
  input  logic                   flag_emergency,
  input  logic                   flag_green,
  input  logic                   flag_yellow,
  input  logic                   flag_red,
  input  logic [15:0]            sequence_number,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             frame_byte,
  output logic                   last_byte
);

  localparam int RAW_LEN = 8 + 4 * THRUST_CHANNELS;

  logic                 push_valid;
  logic                 push_ready;
  logic [RAW_LEN*8-1:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [RAW_LEN*8-1:0] pop_data;

  ccfe_front #(
    .THRUST_CHANNELS(THRUST_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .thrust_0        (thrust_0),
    .thrust_1        (thrust_1),
    .thrust_2        (thrust_2),
    .thrust_3        (thrust_3),
    .flag_emergency  (flag_emergency),
    .flag_green      (flag_green),
    .flag_yellow     (flag_yellow),
    .flag_red        (flag_red),
    .sequence_number (sequence_number),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  ccfe_queue #(
    .WIDTH(RAW_LEN * 8)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  ccfe_back #(
    .THRUST_CHANNELS(THRUST_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (pop_valid),
    .frame_ready (pop_ready),
    .frame_data  (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

endmodule

### bench/tb_crc_cobs_command_frame_encoder.sv
module tb_crc_cobs_command_frame_encoder;
  import ccfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN = 8 + 4 * THRUST_CHANNELS_DEF;
  localparam int IDLE_PCT = 21;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_PAYLOAD_LENGTH + CFG_INDEX_W'(1);

  typedef struct packed {
    logic [3:0][31:0] thrust;
    logic             emergency;
    logic             green;
    logic             yellow;
    logic             red;
    logic [15:0]      seq;
  } command_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  command_t cmd_now = '0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       last_byte;

  // header registers as the block should hold them
  logic [7:0] hdr_version = PROTOCOL_VERSION_RST;
  logic [7:0] hdr_type    = MESSAGE_TYPE_RST;
  logic [7:0] hdr_length  = PAYLOAD_LENGTH_RST;

  command_t   commands_waiting [$];
  wire_byte_t due_bytes [$];
  int         errors = 0;
  int         cycles = 0;
  logic       quiet = 1'b0;

  crc_cobs_command_frame_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .thrust_0       (cmd_now.thrust[0]),
    .thrust_1       (cmd_now.thrust[1]),
    .thrust_2       (cmd_now.thrust[2]),
    .thrust_3       (cmd_now.thrust[3]),
    .flag_emergency (cmd_now.emergency),
    .flag_green     (cmd_now.green),
    .flag_yellow    (cmd_now.yellow),
    .flag_red       (cmd_now.red),
    .sequence_number(cmd_now.seq),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void add_due(input logic [7:0] data, input logic last);
    wire_byte_t b;
    b.data = data;
    b.last = last;
    due_bytes.insert(due_bytes.size(), b);
  endfunction

  function automatic void add_command(input command_t c);
    commands_waiting.insert(commands_waiting.size(), c);
  endfunction

  // raw frame, crc, then cobs stuffing; queues every wire byte of the command
  function automatic void encode_command(input command_t c);
    logic [7:0]  raw [FRAME_LEN];
    logic [7:0]  coded [FRAME_LEN + 2];
    logic [15:0] crc;
    logic [7:0]  flags;
    int          i, k, pos, head, run;
    flags = '0;
    flags[FLAG_BIT_EMERGENCY] = c.emergency;
    flags[FLAG_BIT_GREEN]     = c.green;
    flags[FLAG_BIT_YELLOW]    = c.yellow;
    flags[FLAG_BIT_RED]       = c.red;
    raw[0] = hdr_version;
    raw[1] = hdr_type;
    raw[2] = c.seq[7:0];
    raw[3] = c.seq[15:8];
    raw[4] = hdr_length;
    for (i = 0; i < 4; i++) begin
      for (k = 0; k < 4; k++) begin
        raw[5 + 4 * i + k] = c.thrust[i][8 * k +: 8];
      end
    end
    raw[FRAME_LEN - 3] = flags;
    crc = CRC_INIT;
    for (i = 0; i < FRAME_LEN - 2; i++) begin
      crc = crc ^ {raw[i], 8'h00};
      for (k = 0; k < 8; k++) begin
        crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
      end
    end
    raw[FRAME_LEN - 2] = crc[7:0];
    raw[FRAME_LEN - 1] = crc[15:8];
    pos = 1;
    head = 0;
    run = 1;
    for (i = 0; i < FRAME_LEN; i++) begin
      if (raw[i] == 8'h00) begin
        coded[head] = run[7:0];
        head = pos;
        pos++;
        run = 1;
      end else begin
        coded[pos] = raw[i];
        pos++;
        run++;
        // full block of 254 data bytes closes without a zero
        if (run == 255) begin
          coded[head] = run[7:0];
          head = pos;
          pos++;
          run = 1;
        end
      end
    end
    coded[head] = run[7:0];
    for (i = 0; i < pos; i++) begin
      add_due(coded[i], 1'b0);
    end
    add_due(COBS_DELIM, 1'b1);
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    int          b;
    w = $urandom;
    case ($urandom_range(5))
      0: w = '0;
      1: w = '1;
      2: begin
        // sprinkle zero bytes so the stuffing sees short runs
        for (b = 0; b < 4; b++) begin
          if ($urandom_range(2) == 0) w[8 * b +: 8] = 8'h00;
        end
      end
      3: w = {w[31], 8'($urandom_range(134, 120)), w[22:0]};
      default: ;
    endcase
    return w;
  endfunction

  function automatic command_t pick_command();
    command_t c;
    int       i;
    for (i = 0; i < 4; i++) c.thrust[i] = pick_word();
    c.emergency = 1'($urandom_range(1));
    c.green     = 1'($urandom_range(1));
    c.yellow    = 1'($urandom_range(1));
    c.red       = 1'($urandom_range(1));
    c.seq       = 16'($urandom_range(65535));
    return c;
  endfunction

  function automatic command_t make_command(input logic [31:0] w0, input logic [31:0] w1,
                                            input logic [31:0] w2, input logic [31:0] w3,
                                            input logic [3:0] flags, input logic [15:0] seq);
    command_t c;
    c.thrust    = {w3, w2, w1, w0};
    c.emergency = flags[3];
    c.green     = flags[2];
    c.yellow    = flags[1];
    c.red       = flags[0];
    c.seq       = seq;
    return c;
  endfunction

  task automatic note_error(input string what, input wire_byte_t want, input wire_byte_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.data, want.last, got.data, got.last);
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (in_valid && in_ready) encode_command(cmd_now);
    if (!in_valid || in_ready) begin
      if (!rst && commands_waiting.size() > 0 &&
          (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        cmd_now  <= commands_waiting.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // wire byte monitor
  always @(posedge clk) begin : byte_check
    wire_byte_t want;
    wire_byte_t got;
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && out_valid && out_ready) begin
      got = '{data: frame_byte, last: last_byte};
      if (due_bytes.size() == 0) begin
        note_error("unexpected beat", '0, got);
      end else begin
        want = due_bytes.pop_front();
        if (want.data !== got.data || want.last !== got.last) begin
          note_error("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL crc_cobs_command_frame_encoder");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROTOCOL_VERSION: hdr_version = val;
      REG_MESSAGE_TYPE:     hdr_type = val;
      REG_PAYLOAD_LENGTH:   hdr_length = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (commands_waiting.size() != 0 || in_valid || due_bytes.size() != 0);
  endtask

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic load_random(input int count);
    repeat (count) add_command(pick_command());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset header values, field extremes, each flag alone
    add_command(make_command('0, '0, '0, '0, 4'b0000, 16'h0000));
    add_command(make_command('1, '1, '1, '1, 4'b1111, 16'hFFFF));
    add_command(make_command(32'h3F800000, '0, '0, '0, 4'b1000, 16'h0001));
    add_command(make_command('0, 32'hBF800000, '0, '0, 4'b0100, 16'h0100));
    add_command(make_command('0, '0, 32'h80000000, '0, 4'b0010, 16'h00FF));
    add_command(make_command('0, '0, '0, 32'h7F7FFFFF, 4'b0001, 16'hFF00));
    add_command(make_command(32'h00FF00FF, 32'hFF00FF00, 32'h01000001,
                             32'h00010100, 4'b0101, 16'h8000));
    add_command(make_command(32'hAAAAAAAA, 32'h55555555, 32'h12345678,
                             32'h87654321, 4'b1010, 16'h7FFF));
    wait_drained();

    // write to an unknown index must leave the header alone
    write_reg(REG_FIRST_UNUSED, 8'h5A);
    write_reg(8'hFF, 8'hA5);
    add_command(make_command('1, '0, '1, '0, 4'b0110, 16'h1234));
    wait_drained();

    // all-zero header, payload length not tied to the real size
    write_reg(REG_PROTOCOL_VERSION, 8'h00);
    write_reg(REG_MESSAGE_TYPE, 8'h00);
    write_reg(REG_PAYLOAD_LENGTH, 8'h00);
    add_command(make_command('0, '0, '0, '0, 4'b0000, 16'h0000));
    add_command(make_command('1, '1, '1, '1, 4'b1111, 16'hFFFF));
    wait_drained();

    write_reg(REG_PROTOCOL_VERSION, 8'hFF);
    write_reg(REG_MESSAGE_TYPE, 8'hFF);
    write_reg(REG_PAYLOAD_LENGTH, 8'hFF);
    add_command(make_command('1, '1, '1, '1, 4'b1111, 16'hFFFF));
    add_command(make_command('0, '1, '0, '1, 4'b1001, 16'h00FF));
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_PROTOCOL_VERSION, pick_reg_value());
      write_reg(REG_MESSAGE_TYPE, pick_reg_value());
      write_reg(REG_PAYLOAD_LENGTH, pick_reg_value());
      if ($urandom_range(2) == 0) write_reg(8'($urandom_range(255, REG_FIRST_UNUSED)), 8'($urandom));
      quiet = (phase == 3);
      if (phase == 5) begin
        // sender holds off until every byte of the first half is out
        load_random(25);
        wait_drained();
        load_random(25);
      end else begin
        load_random(50);
      end
      wait_drained();
    end
    quiet = 1'b0;

    repeat (4 * FRAME_LEN) @(posedge clk);
    if (errors == 0 && due_bytes.size() == 0) begin
      $display("PASS crc_cobs_command_frame_encoder");
    end else begin
      $display("FAIL crc_cobs_command_frame_encoder");
    end
    $finish;
  end

endmodule

### crc_cobs_command_frame_encoder.f
design/ccfe_pkg.sv
design/ccfe_front.sv
design/ccfe_queue.sv
design/ccfe_back.sv
design/crc_cobs_command_frame_encoder.sv
bench/tb_crc_cobs_command_frame_encoder.sv
